/* hw/rtl/sha1_block_compression_macros.svh */
// Assertion macros shared by the SHA-1 block compression RTL.
`ifndef SHA1_BLOCK_COMPRESSION_MACROS_SVH
`define SHA1_BLOCK_COMPRESSION_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising edge of clk outside reset.
`define SHA1BC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check that a condition never holds at a rising edge of clk outside reset.
`define SHA1BC_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define SHA1BC_ASSERT(lbl, prop, msg)
`define SHA1BC_NEVER(lbl, expr, msg)
`endif
`endif

/* hw/rtl/sha1bc_pkg.sv */
// Types, constants and round functions of the SHA-1 block compression.
`timescale 1ns / 1ps
`default_nettype none
package sha1bc_pkg;

  localparam int WordW         = 32;
  localparam int ChainWords    = 5;
  localparam int ScheduleWords = 16;
  localparam int RoundW        = 7;
  localparam int WordIdxW      = 4;
  localparam int QueueDepth    = 4;

  // Last round of each round-function group.
  localparam int RoundF1Last = 19;
  localparam int RoundF2Last = 39;
  localparam int RoundF3Last = 59;
  localparam int RoundLast   = 79;

  // Rotations of the round.
  localparam int RotA = 5;
  localparam int RotB = 30;
  localparam int RotW = 1;

  localparam logic [WordW-1:0] Iv [ChainWords] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [WordW-1:0] K1 = 32'h5A827999;
  localparam logic [WordW-1:0] K2 = 32'h6ED9EBA1;
  localparam logic [WordW-1:0] K3 = 32'h8F1BBCDC;
  localparam logic [WordW-1:0] K4 = 32'hCA62C1D6;

  typedef struct packed {
    logic [WordW-1:0] message_word;
    logic             new_message;
    logic             final_block;
  } msg_in_t;

  typedef struct packed {
    logic [WordW-1:0] digest_word;
    logic             digest_last;
  } digest_out_t;

  // One word request as it travels from the front to the back.
  typedef struct packed {
    logic [WordW-1:0] message_word;
    logic             new_message;
    logic             block_end;
    logic             final_block;
  } word_req_t;

  typedef enum logic [1:0] {
    BACK_LOAD,
    BACK_ROUND,
    BACK_FINISH
  } back_state_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x, input int n);
    rotl = (x << n) | (x >> (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] round_f(input logic [RoundW-1:0] t,
                                               input logic [WordW-1:0] b,
                                               input logic [WordW-1:0] c,
                                               input logic [WordW-1:0] d);
    if (t <= RoundW'(RoundF1Last)) begin
      round_f = (b & c) | (~b & d);
    end else if (t <= RoundW'(RoundF2Last)) begin
      round_f = b ^ c ^ d;
    end else if (t <= RoundW'(RoundF3Last)) begin
      round_f = (b & c) | (b & d) | (c & d);
    end else begin
      round_f = b ^ c ^ d;
    end
  endfunction

  function automatic logic [WordW-1:0] round_k(input logic [RoundW-1:0] t);
    if (t <= RoundW'(RoundF1Last)) begin
      round_k = K1;
    end else if (t <= RoundW'(RoundF2Last)) begin
      round_k = K2;
    end else if (t <= RoundW'(RoundF3Last)) begin
      round_k = K3;
    end else begin
      round_k = K4;
    end
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/sha1bc_front.sv */
// Front end: accepts message words, tracks word position, tags block ends.
`timescale 1ns / 1ps
`default_nettype none
module sha1bc_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  msg_valid,
  output logic                       msg_ready,
  input  wire sha1bc_pkg::msg_in_t   msg,
  input  wire logic                  queue_full,
  output logic                       push,
  output sha1bc_pkg::word_req_t      req
);

  logic [sha1bc_pkg::WordIdxW-1:0] word_count;
  logic [sha1bc_pkg::WordIdxW-1:0] word_idx;

  // Take a request whenever the queue has room.
  assign msg_ready = !queue_full;
  assign push      = msg_valid && msg_ready;

  // A new message restarts the block at word zero.
  assign word_idx = msg.new_message ? '0 : word_count;

  always_comb begin
    req.message_word = msg.message_word;
    req.new_message  = msg.new_message;
    req.block_end    = (word_idx == sha1bc_pkg::WordIdxW'(sha1bc_pkg::ScheduleWords - 1));
    req.final_block  = msg.final_block;
  end

  // Advance the word position; it wraps to zero after the block end.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_count <= '0;
    end else if (push) begin
      word_count <= word_idx + 1'b1;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sha1bc_queue.sv */
// Short request queue between the front end and the compression engine.
`timescale 1ns / 1ps
`default_nettype none
module sha1bc_queue #(
  parameter int DEPTH = sha1bc_pkg::QueueDepth
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   push,
  input  wire sha1bc_pkg::word_req_t  push_req,
  input  wire logic                   pop,
  output sha1bc_pkg::word_req_t       head,
  output logic                        head_valid,
  output logic                        full
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  sha1bc_pkg::word_req_t entries [DEPTH];
  logic [PtrW-1:0]       wr_ptr;
  logic [PtrW-1:0]       rd_ptr;
  logic [CntW-1:0]       count;
  logic                  do_push;
  logic                  do_pop;

  assign head       = entries[rd_ptr];
  assign head_valid = (count != '0);
  assign full       = (count == CntW'(DEPTH));
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Store the pushed request.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_req;
    end
  end

  // Advance pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/sha1bc_back.sv */
// Compression engine: schedule window, 80 rounds, chaining update, digest out.
`timescale 1ns / 1ps
`default_nettype none
`include "sha1_block_compression_macros.svh"
module sha1bc_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire sha1bc_pkg::word_req_t  head,
  input  wire logic                   head_valid,
  output logic                        pop,
  output logic                        digest_valid,
  input  wire logic                   digest_ready,
  output sha1bc_pkg::digest_out_t     digest
);

  localparam int W  = sha1bc_pkg::WordW;
  localparam int NC = sha1bc_pkg::ChainWords;
  localparam int NS = sha1bc_pkg::ScheduleWords;
  localparam int RW = sha1bc_pkg::RoundW;
  localparam int DcW = $clog2(NC + 1);

  sha1bc_pkg::back_state_t state;
  sha1bc_pkg::back_state_t state_next;

  logic [W-1:0]  chain  [NC];
  logic [W-1:0]  vars   [NC];
  logic [W-1:0]  window [NS];
  logic [W-1:0]  digest_buf [NC];
  logic [DcW-1:0] digest_count;
  logic [RW-1:0] round_count;
  logic          final_pending;
  logic          digest_busy;
  logic          last_round;

  logic [W-1:0]  w_sched;
  logic [W-1:0]  w_round;
  logic [W-1:0]  tmp;

  assign digest_busy = (digest_count != '0);
  assign last_round  = (round_count == RW'(sha1bc_pkg::RoundLast));

  // Expand the schedule and form the round sum.
  always_comb begin
    w_sched = sha1bc_pkg::rotl(window[13] ^ window[8] ^ window[2] ^ window[0],
                               sha1bc_pkg::RotW);
    w_round = (round_count < RW'(NS)) ? window[0] : w_sched;
    tmp = sha1bc_pkg::rotl(vars[0], sha1bc_pkg::RotA)
        + sha1bc_pkg::round_f(round_count, vars[1], vars[2], vars[3])
        + vars[4] + w_round + sha1bc_pkg::round_k(round_count);
  end

  // Next state and request pop; hold a final block end while a digest drains.
  always_comb begin
    state_next = state;
    pop        = 1'b0;
    unique case (state)
      sha1bc_pkg::BACK_LOAD: begin
        pop = head_valid && !(head.block_end && head.final_block && digest_busy);
        if (pop && head.block_end) begin
          state_next = sha1bc_pkg::BACK_ROUND;
        end
      end
      sha1bc_pkg::BACK_ROUND: begin
        if (last_round) begin
          state_next = sha1bc_pkg::BACK_FINISH;
        end
      end
      sha1bc_pkg::BACK_FINISH: begin
        state_next = sha1bc_pkg::BACK_LOAD;
      end
      default: begin
        state_next = sha1bc_pkg::BACK_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha1bc_pkg::BACK_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Schedule window: shift in loaded words, recirculate during rounds.
  always_ff @(posedge clk) begin
    if ((state == sha1bc_pkg::BACK_LOAD && pop) || state == sha1bc_pkg::BACK_ROUND) begin
      for (int i = 0; i < NS - 1; i++) begin
        window[i] <= window[i+1];
      end
      window[NS-1] <= (state == sha1bc_pkg::BACK_ROUND) ? w_round : head.message_word;
    end
  end

  // Chaining value, working variables, round counter and digest buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NC; i++) begin
        chain[i] <= sha1bc_pkg::Iv[i];
        vars[i]  <= '0;
      end
      round_count   <= '0;
      final_pending <= 1'b0;
      digest_count  <= '0;
    end else begin
      // Drain the digest one word per accepted request.
      if (digest_valid && digest_ready) begin
        for (int i = 0; i < NC - 1; i++) begin
          digest_buf[i] <= digest_buf[i+1];
        end
        digest_count <= digest_count - 1'b1;
      end
      case (state)
        sha1bc_pkg::BACK_LOAD: begin
          if (pop) begin
            if (head.new_message) begin
              for (int i = 0; i < NC; i++) begin
                chain[i] <= sha1bc_pkg::Iv[i];
              end
            end
            if (head.block_end) begin
              for (int i = 0; i < NC; i++) begin
                vars[i] <= head.new_message ? sha1bc_pkg::Iv[i] : chain[i];
              end
              final_pending <= head.final_block;
            end
          end
        end
        sha1bc_pkg::BACK_ROUND: begin
          vars[0] <= tmp;
          vars[1] <= vars[0];
          vars[2] <= sha1bc_pkg::rotl(vars[1], sha1bc_pkg::RotB);
          vars[3] <= vars[2];
          vars[4] <= vars[3];
          round_count <= last_round ? '0 : round_count + 1'b1;
        end
        sha1bc_pkg::BACK_FINISH: begin
          for (int i = 0; i < NC; i++) begin
            chain[i] <= chain[i] + vars[i];
          end
          if (final_pending) begin
            for (int i = 0; i < NC; i++) begin
              digest_buf[i] <= chain[i] + vars[i];
            end
            digest_count <= DcW'(NC);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign digest_valid       = digest_busy;
  assign digest.digest_word = digest_buf[0];
  assign digest.digest_last = (digest_count == DcW'(1));

  `SHA1BC_ASSERT(a_round_idle_zero, (state != sha1bc_pkg::BACK_ROUND) |-> (round_count == '0), "round counter not zero outside rounds")
  `SHA1BC_NEVER(a_no_pop_busy, pop && (state != sha1bc_pkg::BACK_LOAD), "request popped while compressing")
  `SHA1BC_ASSERT(a_last_to_finish, (state == sha1bc_pkg::BACK_ROUND && last_round) |=> (state == sha1bc_pkg::BACK_FINISH), "round 79 not followed by chaining update")
  `SHA1BC_NEVER(a_digest_overrun, (state == sha1bc_pkg::BACK_FINISH) && final_pending && digest_busy, "digest buffer overwritten while draining")

endmodule
`default_nettype wire

/* hw/rtl/sha1_block_compression.sv */
// SHA-1 block compression: 16-word blocks in, 5-word digest out.
// Each 16-word block is loaded word by word, then runs 80 rounds and one chaining
// update on the single round unit; the engine takes no new word until these are done.
// The 4-entry request queue keeps taking words while the rounds run, until it is full.
// Reset: chaining value to the SHA-1 initial value, queue and digest empty.
`timescale 1ns / 1ps
`default_nettype none
module sha1_block_compression #(
  parameter int QUEUE_DEPTH = sha1bc_pkg::QueueDepth
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     msg_valid,
  output logic                          msg_ready,
  input  wire sha1bc_pkg::msg_in_t      msg,
  output logic                          digest_valid,
  input  wire logic                     digest_ready,
  output sha1bc_pkg::digest_out_t       digest
);

  sha1bc_pkg::word_req_t push_req;
  sha1bc_pkg::word_req_t head;
  logic                  push;
  logic                  pop;
  logic                  head_valid;
  logic                  queue_full;

  sha1bc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .msg_valid  (msg_valid),
    .msg_ready  (msg_ready),
    .msg        (msg),
    .queue_full (queue_full),
    .push       (push),
    .req        (push_req)
  );

  sha1bc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_req   (push_req),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (queue_full)
  );

  sha1bc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .head_valid   (head_valid),
    .pop          (pop),
    .digest_valid (digest_valid),
    .digest_ready (digest_ready),
    .digest       (digest)
  );

endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking testbench for the SHA-1 block compression with a built-in digest predictor.
`timescale 1ns / 1ps
module testbench;

  localparam logic [159:0] SHA1_INIT  = 160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
  // Digest of the three-byte message "abc", single padded block.
  localparam logic [159:0] ABC_DIGEST = 160'hA9993E36_4706816A_BA3E2571_7850C26C_9CD0D89D;
  localparam logic [31:0]  ABC_WORD0  = 32'h61626380;
  localparam logic [31:0]  ABC_LENGTH = 32'h00000018;
  localparam int           DRAIN_CYCLES = 200;

  typedef struct {
    sha1bc_pkg::msg_in_t req;
    bit                  has_known;
    logic [159:0]        known;
  } stim_row_t;

  logic                    clk;
  logic                    rst;
  logic                    msg_valid;
  logic                    msg_ready;
  sha1bc_pkg::msg_in_t     msg;
  logic                    digest_valid;
  logic                    digest_ready;
  sha1bc_pkg::digest_out_t digest;

  // Predictor state
  logic [31:0] chain [5];
  logic [31:0] sched [16];
  logic [3:0]  blk_pos;

  sha1bc_pkg::digest_out_t digest_expect [$];
  stim_row_t               dir_rows [$];

  int  errors = 0;
  int  words_sent = 0;
  int  blocks_done = 0;
  int  digests_queued = 0;
  int  results_checked = 0;
  int  stall_left = 0;
  bit  steady_tail = 0;

  sha1_block_compression uut (
    .clk         (clk),
    .rst         (rst),
    .msg_valid   (msg_valid),
    .msg_ready   (msg_ready),
    .msg         (msg),
    .digest_valid(digest_valid),
    .digest_ready(digest_ready),
    .digest      (digest)
  );

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [31:0] rol32(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: MISMATCH %s: got %h, expected %h", $time, what, got, want);
    errors++;
  endtask

  task automatic load_init_chain();
    for (int i = 0; i < 5; i++) chain[i] = SHA1_INIT[159 - 32 * i -: 32];
  endtask

  // Run 80 rounds over the schedule window and fold into the chaining value.
  task automatic compress_window();
    logic [31:0] a, b, c, d, e, f, k, w, t;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (int r = 0; r < 80; r++) begin
      if (r >= 16) begin
        w = rol32(sched[(r - 3) & 15] ^ sched[(r - 8) & 15] ^
                  sched[(r - 14) & 15] ^ sched[r & 15], 1);
        sched[r & 15] = w;
      end else begin
        w = sched[r];
      end
      if (r < 20) begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
      t = rol32(a, 5) + f + e + w + k;
      e = d;
      d = c;
      c = rol32(b, 30);
      b = a;
      a = t;
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    chain[4] += e;
  endtask

  task automatic queue_digest(input logic [159:0] dg);
    sha1bc_pkg::digest_out_t x;
    for (int i = 0; i < 5; i++) begin
      x.digest_word = dg[159 - 32 * i -: 32];
      x.digest_last = (i == 4);
      digest_expect.push_back(x);
    end
    digests_queued++;
  endtask

  // Advance the predictor by one accepted request.
  task automatic absorb_word(input sha1bc_pkg::msg_in_t w, input bit has_known,
                             input logic [159:0] known);
    if (w.new_message) begin
      load_init_chain();
      blk_pos = '0;
    end
    sched[blk_pos] = w.message_word;
    if (blk_pos != 4'd15) begin
      blk_pos++;
    end else begin
      blk_pos = '0;
      compress_window();
      blocks_done++;
      if (w.final_block) begin
        queue_digest(has_known ? known : {chain[0], chain[1], chain[2], chain[3], chain[4]});
      end
    end
  endtask

  // Drive one request, with an occasional idle burst ahead of it.
  task automatic push_word(input sha1bc_pkg::msg_in_t w, input bit has_known,
                           input logic [159:0] known);
    int gap;
    gap = 0;
    if (!steady_tail && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      @(negedge clk);
      msg_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    msg       <= w;
    msg_valid <= 1'b1;
    @(posedge clk);
    while (!msg_ready) @(posedge clk);
    words_sent++;
    absorb_word(w, has_known, known);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'h00000000;
      1:       return 32'hFFFFFFFF;
      2:       return 32'h1 << $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  task automatic add_row(input logic [31:0] word, input bit first, input bit last_blk,
                         input bit has_known, input logic [159:0] known);
    stim_row_t row;
    row.req.message_word = word;
    row.req.new_message  = first;
    row.req.final_block  = last_blk;
    row.has_known        = has_known;
    row.known            = known;
    dir_rows.push_back(row);
  endtask

  // Send one padded message of nblk blocks; closes decides whether a digest comes out.
  task automatic send_message(input int nblk, input bit fresh, input bit closes);
    sha1bc_pkg::msg_in_t w;
    for (int b = 0; b < nblk; b++) begin
      for (int i = 0; i < 16; i++) begin
        w.message_word = pick_word();
        w.new_message  = (b == 0 && i == 0 && fresh);
        w.final_block  = (i == 15) ? (closes && b == nblk - 1) : 1'($urandom_range(0, 1));
        push_word(w, 1'b0, '0);
      end
    end
  endtask

  // Receiver backpressure: random stall bursts, none in the tail
  always @(negedge clk) begin
    if (stall_left > 0) begin
      digest_ready <= 1'b0;
      stall_left--;
    end else if (!steady_tail && !rst && $urandom_range(0, 5) == 0) begin
      digest_ready <= 1'b0;
      stall_left = $urandom_range(1, 16) - 1;
    end else begin
      digest_ready <= 1'b1;
    end
  end

  // Check each digest word against the oldest expectation
  always @(posedge clk) begin
    sha1bc_pkg::digest_out_t want;
    if (!rst && digest_valid && digest_ready) begin
      results_checked++;
      if (digest_expect.size() == 0) begin
        report_mismatch("unexpected digest word", digest.digest_word, 32'h0);
      end else begin
        want = digest_expect.pop_front();
        if (digest.digest_word !== want.digest_word)
          report_mismatch("digest_word", digest.digest_word, want.digest_word);
        if (digest.digest_last !== want.digest_last)
          report_mismatch("digest_last", 32'(digest.digest_last), 32'(want.digest_last));
      end
    end
  end

  // Main stimulus
  initial begin
    sha1bc_pkg::msg_in_t w;
    int                  kind;
    int                  nmsg;

    rst          = 1'b1;
    msg_valid    = 1'b0;
    msg          = '0;
    load_init_chain();
    for (int i = 0; i < 16; i++) sched[i] = '0;
    blk_pos = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: stray words right after reset (final flag ignored off the 16th word),
    // then a restart mid-block that drops them, then the padded "abc" block.
    add_row(32'hFFFFFFFF, 1'b0, 1'b1, 1'b0, '0);
    add_row(32'h00000000, 1'b0, 1'b0, 1'b0, '0);
    add_row(32'h80000001, 1'b0, 1'b1, 1'b0, '0);
    add_row(ABC_WORD0, 1'b1, 1'b1, 1'b0, '0);
    for (int i = 1; i < 15; i++) add_row(32'h0, 1'b0, 1'(i % 2), 1'b0, '0);
    add_row(ABC_LENGTH, 1'b0, 1'b1, 1'b1, ABC_DIGEST);

    foreach (dir_rows[i]) push_word(dir_rows[i].req, dir_rows[i].has_known, dir_rows[i].known);

    // Random: mostly well-formed messages, some chained without a restart,
    // some left open, and some broken partial blocks.
    nmsg = 0;
    while (words_sent < 120) begin
      if (words_sent >= 90) steady_tail = 1'b1;
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(1, 15)) begin
          w.message_word = pick_word();
          w.new_message  = ($urandom_range(0, 3) == 0);
          w.final_block  = 1'($urandom_range(0, 1));
          push_word(w, 1'b0, '0);
        end
      end else begin
        send_message(($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1,
                     (blk_pos != 0) || ($urandom_range(0, 3) != 0), kind != 1);
        nmsg++;
      end
    end

    @(negedge clk);
    msg_valid <= 1'b0;

    // Drain outstanding digests, then give the block time to misbehave
    while (digest_expect.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d message words (%0d random messages), %0d blocks compressed.",
             words_sent, nmsg, blocks_done);
    $display("Checked %0d digest words from %0d digests, %0d mismatches.",
             results_checked, digests_queued, errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
